@@ hdl/epoch_seconds_to_calendar_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the epoch seconds to calendar converter
// Wraps concurrent assertions so that synthesis sees empty text.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ESC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ESC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hdl/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  localparam int NUM_STAGES = 6;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctl_t;

  // q = (x * RECIP) >> SHIFT, exact over the operand range used
  localparam logic [25:0] DAY_RECIP   = 26'd50903317;  // 1/675, x < 2^25
  localparam int          DAY_SHIFT   = 35;
  localparam logic [16:0] CYC_RECIP   = 17'd91868;     // 1/1461, x < 2^16
  localparam int          CYC_SHIFT   = 27;
  localparam logic [16:0] WK_RECIP    = 17'd74899;     // 1/7, x < 2^16
  localparam int          WK_SHIFT    = 19;
  localparam logic [13:0] HR_RECIP    = 14'd9321;      // 1/225, x < 2^13
  localparam int          HR_SHIFT    = 21;
  localparam logic [10:0] MIN_RECIP   = 11'd1093;      // 1/15, x < 2^10
  localparam int          MIN_SHIFT   = 14;

  localparam logic [9:0]  DAY_ODD     = 10'd675;       // 86400 >> 7
  localparam logic [10:0] DAYS_PER_CYC = 11'd1461;
  localparam logic [8:0]  DAYS_PER_YR = 9'd365;
  localparam logic [11:0] SECS_PER_HR = 12'd3600;
  localparam logic [6:0]  SECS_PER_MIN = 7'd60;

  // day count is rebased to 1968-03-01, the start of a four-year cycle
  localparam logic [15:0] BASE_OFFSET = 16'd671;
  // rebased index of 2100-03-01; a phantom Feb 29 is inserted before it
  localparam logic [15:0] MAR_2100    = 16'd48212;
  localparam logic [5:0]  CYC_2100    = 6'd33;
  localparam logic [11:0] BASE_YEAR   = 12'd1968;
  localparam logic [2:0]  EPOCH_WDAY  = 3'd4;

  localparam logic [3:0]  MP_JAN      = 4'd10;
  localparam logic [8:0]  JAN1_OFFSET = 9'd306;
  localparam logic [8:0]  MAR1_DOY    = 9'd59;

  // first day of each month in a March-based year
  localparam logic [8:0] MAR_MONTH_START [0:11] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

endpackage

`default_nettype wire

@@ hdl/esc_pipe_ctl.sv @@
// ----------------------------------------------------------------------------
// esc_pipe_ctl
// Valid bits and stage load enables for the converter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_pipe_ctl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output esc_pkg::pipe_ctl_t     ctl
);

  logic [esc_pkg::NUM_STAGES-1:0] valid_r;
  logic [esc_pkg::NUM_STAGES-1:0] valid_nxt;
  logic [esc_pkg::NUM_STAGES-1:0] load;
  logic [esc_pkg::NUM_STAGES-1:0] upstream;

  // a stage takes new data when empty or when its content moves on
  always_comb begin
    load[esc_pkg::NUM_STAGES-1] = !valid_r[esc_pkg::NUM_STAGES-1] || out_ready;
    for (int k = esc_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !valid_r[k] || load[k+1];
    end
  end

  always_comb begin
    upstream = {valid_r[esc_pkg::NUM_STAGES-2:0], in_valid};
    for (int k = 0; k < esc_pkg::NUM_STAGES; k++) begin
      valid_nxt[k] = load[k] ? upstream[k] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = load[0];
  assign out_valid = valid_r[esc_pkg::NUM_STAGES-1];
  assign ctl.load  = load;
  assign ctl.valid = valid_r;

endmodule

`default_nettype wire

@@ hdl/epoch_seconds_to_calendar.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts a 32-bit Unix time stamp into its UTC calendar breakdown.
//
// One transaction in gives one transaction out, and a new time stamp can be
// taken every cycle unless the result side stalls a full pipeline. The pipeline
// follows the chain of constant-reciprocal multiplies: seconds to days, days to
// four-year cycles, weekday and hour, then minute, each followed by a register.
// The day count is rebased to 1968-03-01 so that Feb 29 ends each four-year
// cycle; 2100 is not a leap year, handled by skipping over a phantom Feb 29
// 2100. When the result side stalls, the pipeline fills up and in_ready drops
// only once every stage holds a transaction.
// ----------------------------------------------------------------------------
`default_nettype none
`include "epoch_seconds_to_calendar_assert.svh"

module epoch_seconds_to_calendar (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day_of_month,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic [2:0]       out_weekday,
  output logic [8:0]       out_day_of_year
);

  esc_pkg::pipe_ctl_t ctl;

  esc_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // ---------------- stage 0: seconds / 86400 product
  logic [31:0] s0_t_r,     s0_t_nxt;
  logic [50:0] s0_dprod_r, s0_dprod_nxt;

  always_comb begin
    s0_t_nxt     = in_epoch_seconds;
    s0_dprod_nxt = 51'(in_epoch_seconds[31:7]) * 51'(esc_pkg::DAY_RECIP);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s0_t_r     <= s0_t_nxt;
      s0_dprod_r <= s0_dprod_nxt;
    end
  end

  // ---------------- stage 1: day number, time of day, rebased day
  logic [15:0] s1_days_r, s1_days_nxt;
  logic [16:0] s1_tod_r,  s1_tod_nxt;
  logic [15:0] s1_dreb_r, s1_dreb_nxt;

  always_comb begin
    logic [15:0] days;
    logic [31:0] day_secs;
    logic [15:0] dbase;
    days        = s0_dprod_r[50:esc_pkg::DAY_SHIFT];
    day_secs    = 32'(days) * 32'(esc_pkg::DAY_ODD) << 7;
    dbase       = days + esc_pkg::BASE_OFFSET;
    s1_days_nxt = days;
    s1_tod_nxt  = 17'(s0_t_r - day_secs);
    s1_dreb_nxt = dbase + 16'(dbase >= esc_pkg::MAR_2100);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s1_days_r <= s1_days_nxt;
      s1_tod_r  <= s1_tod_nxt;
      s1_dreb_r <= s1_dreb_nxt;
    end
  end

  // ---------------- stage 2: cycle, weekday and hour products
  logic [15:0] s2_dreb_r,  s2_dreb_nxt;
  logic [32:0] s2_qprod_r, s2_qprod_nxt;
  logic [15:0] s2_wx_r,    s2_wx_nxt;
  logic [32:0] s2_wprod_r, s2_wprod_nxt;
  logic [16:0] s2_tod_r,   s2_tod_nxt;
  logic [26:0] s2_hprod_r, s2_hprod_nxt;

  always_comb begin
    s2_dreb_nxt  = s1_dreb_r;
    s2_qprod_nxt = 33'(s1_dreb_r) * 33'(esc_pkg::CYC_RECIP);
    s2_wx_nxt    = s1_days_r + 16'(esc_pkg::EPOCH_WDAY);
    s2_wprod_nxt = 33'(s2_wx_nxt) * 33'(esc_pkg::WK_RECIP);
    s2_tod_nxt   = s1_tod_r;
    s2_hprod_nxt = 27'(s1_tod_r[16:4]) * 27'(esc_pkg::HR_RECIP);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s2_dreb_r  <= s2_dreb_nxt;
      s2_qprod_r <= s2_qprod_nxt;
      s2_wx_r    <= s2_wx_nxt;
      s2_wprod_r <= s2_wprod_nxt;
      s2_tod_r   <= s2_tod_nxt;
      s2_hprod_r <= s2_hprod_nxt;
    end
  end

  // ---------------- stage 3: cycle remainder, weekday, hour, hour remainder
  logic [5:0]  s3_q_r,       s3_q_nxt;
  logic [10:0] s3_rem_r,     s3_rem_nxt;
  logic [2:0]  s3_weekday_r, s3_weekday_nxt;
  logic [4:0]  s3_hour_r,    s3_hour_nxt;
  logic [11:0] s3_remh_r,    s3_remh_nxt;

  always_comb begin
    logic [13:0] wq;
    s3_q_nxt       = s2_qprod_r[32:esc_pkg::CYC_SHIFT];
    s3_rem_nxt     = 11'(s2_dreb_r - 16'(s3_q_nxt) * 16'(esc_pkg::DAYS_PER_CYC));
    wq             = s2_wprod_r[32:esc_pkg::WK_SHIFT];
    s3_weekday_nxt = 3'(s2_wx_r - ({2'd0, wq} << 3) + {2'd0, wq});
    s3_hour_nxt    = s2_hprod_r[25:esc_pkg::HR_SHIFT];
    s3_remh_nxt    = 12'(s2_tod_r - 17'(s3_hour_nxt) * 17'(esc_pkg::SECS_PER_HR));
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s3_q_r       <= s3_q_nxt;
      s3_rem_r     <= s3_rem_nxt;
      s3_weekday_r <= s3_weekday_nxt;
      s3_hour_r    <= s3_hour_nxt;
      s3_remh_r    <= s3_remh_nxt;
    end
  end

  // ---------------- stage 4: year within cycle, March-based day, minute product
  logic [5:0]  s4_q_r,       s4_q_nxt;
  logic [1:0]  s4_yc_r,      s4_yc_nxt;
  logic [8:0]  s4_doy_r,     s4_doy_nxt;
  logic [2:0]  s4_weekday_r, s4_weekday_nxt;
  logic [4:0]  s4_hour_r,    s4_hour_nxt;
  logic [11:0] s4_remh_r,    s4_remh_nxt;
  logic [20:0] s4_mprod_r,   s4_mprod_nxt;

  always_comb begin
    // last year of a cycle takes the leap day, so the count caps at three
    priority if (s3_rem_r >= 11'(3 * esc_pkg::DAYS_PER_YR)) begin
      s4_yc_nxt = 2'd3;
    end else if (s3_rem_r >= 11'(2 * esc_pkg::DAYS_PER_YR)) begin
      s4_yc_nxt = 2'd2;
    end else if (s3_rem_r >= 11'(esc_pkg::DAYS_PER_YR)) begin
      s4_yc_nxt = 2'd1;
    end else begin
      s4_yc_nxt = 2'd0;
    end
    s4_doy_nxt     = 9'(s3_rem_r - 11'(s4_yc_nxt) * 11'(esc_pkg::DAYS_PER_YR));
    s4_q_nxt       = s3_q_r;
    s4_weekday_nxt = s3_weekday_r;
    s4_hour_nxt    = s3_hour_r;
    s4_remh_nxt    = s3_remh_r;
    s4_mprod_nxt   = 21'(s3_remh_r[11:2]) * 21'(esc_pkg::MIN_RECIP);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      s4_q_r       <= s4_q_nxt;
      s4_yc_r      <= s4_yc_nxt;
      s4_doy_r     <= s4_doy_nxt;
      s4_weekday_r <= s4_weekday_nxt;
      s4_hour_r    <= s4_hour_nxt;
      s4_remh_r    <= s4_remh_nxt;
      s4_mprod_r   <= s4_mprod_nxt;
    end
  end

  // ---------------- stage 5: month, day, year, minute, second (output register)
  logic [11:0] s5_year_r,    s5_year_nxt;
  logic [3:0]  s5_month_r,   s5_month_nxt;
  logic [4:0]  s5_mday_r,    s5_mday_nxt;
  logic [4:0]  s5_hour_r,    s5_hour_nxt;
  logic [5:0]  s5_minute_r,  s5_minute_nxt;
  logic [5:0]  s5_second_r,  s5_second_nxt;
  logic [2:0]  s5_weekday_r, s5_weekday_nxt;
  logic [8:0]  s5_yday_r,    s5_yday_nxt;

  always_comb begin
    logic [3:0] mp;
    logic       jan_feb;
    logic       leap;
    mp = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (s4_doy_r >= esc_pkg::MAR_MONTH_START[k]) begin
        mp = 4'(k);
      end
    end
    jan_feb       = (mp >= esc_pkg::MP_JAN);
    // first year of each cycle is leap, except the one starting in 2100
    leap          = (s4_yc_r == 2'd0) && (s4_q_r != esc_pkg::CYC_2100);
    s5_month_nxt  = jan_feb ? mp - 4'd9 : mp + 4'd3;
    s5_mday_nxt   = 5'(s4_doy_r - esc_pkg::MAR_MONTH_START[mp] + 9'd1);
    s5_year_nxt   = esc_pkg::BASE_YEAR + {4'd0, s4_q_r, 2'd0} + 12'(s4_yc_r)
                    + 12'(jan_feb);
    s5_yday_nxt   = jan_feb ? s4_doy_r - esc_pkg::JAN1_OFFSET
                            : s4_doy_r + esc_pkg::MAR1_DOY + 9'(leap);
    s5_minute_nxt = s4_mprod_r[19:esc_pkg::MIN_SHIFT];
    s5_second_nxt = 6'(s4_remh_r - 12'(s5_minute_nxt) * 12'(esc_pkg::SECS_PER_MIN));
    s5_hour_nxt   = s4_hour_r;
    s5_weekday_nxt = s4_weekday_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      s5_year_r    <= s5_year_nxt;
      s5_month_r   <= s5_month_nxt;
      s5_mday_r    <= s5_mday_nxt;
      s5_hour_r    <= s5_hour_nxt;
      s5_minute_r  <= s5_minute_nxt;
      s5_second_r  <= s5_second_nxt;
      s5_weekday_r <= s5_weekday_nxt;
      s5_yday_r    <= s5_yday_nxt;
    end
  end

  assign out_year         = s5_year_r;
  assign out_month        = s5_month_r;
  assign out_day_of_month = s5_mday_r;
  assign out_hour         = s5_hour_r;
  assign out_minute       = s5_minute_r;
  assign out_second       = s5_second_r;
  assign out_weekday      = s5_weekday_r;
  assign out_day_of_year  = s5_yday_r;

  // ---------------- assertions
  `ESC_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, ctl.valid[0], "accepted transaction did not enter the pipeline")
  `ESC_ASSERT_IMPLY(a_stall_full, clk, rst_n, !in_ready, (&ctl.valid) && !out_ready, "input stalled with a bubble in the pipeline")
  `ESC_ASSERT_IMPLY(a_date_range, clk, rst_n, out_valid, out_month >= 4'd1 && out_month <= 4'd12 && out_day_of_month >= 5'd1 && out_day_of_year <= 9'd365, "date field out of range")
  `ESC_ASSERT_IMPLY(a_time_range, clk, rst_n, out_valid, out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59 && out_weekday <= 3'd6, "time field out of range")

endmodule

`default_nettype wire
